FILE: rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types and constants of the 3x3 median filter: pixel type, register
// widths and reset values, window size and the stage tag of the median tree.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int PIXEL_BITS        = 8;
    localparam int DEFAULT_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT        = 4096;
    localparam int ROW_BITS          = 13;
    localparam int WIN_CELLS         = 9;
    localparam int FIFO_DEPTH        = 8;

    localparam int CFG_ADDR_BITS     = 3;
    localparam int CFG_DATA_BITS     = 32;
    localparam int WIDTH_REG_BITS    = 11;
    localparam int HEIGHT_REG_BITS   = 13;
    localparam int WIDTH_RESET       = 1024;
    localparam int HEIGHT_RESET      = 1024;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    // travels alongside an item through the median tree
    typedef struct packed {
        logic valid;
        logic last;
    } med_tag_t;

endpackage

FILE: rtl/mf3_stream_if.sv
// ----------------------------------------------------------------------------
// mf3_stream_if
// Valid/ready channels of the median filter: the pixel stream in and the
// median stream out.
// ----------------------------------------------------------------------------
interface mf3_pixel_if;
    logic            valid;
    logic            ready;
    logic            cmd;
    mf3_pkg::pixel_t pixel;

    modport source (output valid, output cmd, output pixel, input ready);
    modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

interface mf3_result_if;
    logic            valid;
    logic            ready;
    mf3_pkg::pixel_t median;
    logic            last;

    modport source (output valid, output median, output last, input ready);
    modport sink   (input valid, input median, input last, output ready);
endinterface

FILE: rtl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Simple dual-port RAM: one write port, one read port with registered read
// data. A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// Three-stage median-of-nine network: sort each window column, take the
// max of lows, median of mids and min of highs, then the median of those.
// ----------------------------------------------------------------------------
module mf3_median (
    input  logic               clk,
    input  logic               rst_n,
    input  mf3_pkg::med_tag_t  tag_in,
    input  mf3_pkg::pixel_t    cells [mf3_pkg::WIN_CELLS],
    output mf3_pkg::med_tag_t  tag_out,
    output mf3_pkg::pixel_t    median
);

    function automatic mf3_pkg::pixel_t min2(input mf3_pkg::pixel_t a, input mf3_pkg::pixel_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf3_pkg::pixel_t max2(input mf3_pkg::pixel_t a, input mf3_pkg::pixel_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic mf3_pkg::pixel_t med3(input mf3_pkg::pixel_t a,
                                             input mf3_pkg::pixel_t b,
                                             input mf3_pkg::pixel_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    mf3_pkg::med_tag_t tag_a_reg, tag_b_reg, tag_c_reg;
    mf3_pkg::pixel_t   lo_next  [3];
    mf3_pkg::pixel_t   mid_next [3];
    mf3_pkg::pixel_t   hi_next  [3];
    mf3_pkg::pixel_t   lo_reg   [3];
    mf3_pkg::pixel_t   mid_reg  [3];
    mf3_pkg::pixel_t   hi_reg   [3];
    mf3_pkg::pixel_t   max_lo_reg, med_mid_reg, min_hi_reg, median_reg;

    // sort each column of three
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            lo_next[c]  = min2(min2(cells[c*3], cells[c*3+1]), cells[c*3+2]);
            hi_next[c]  = max2(max2(cells[c*3], cells[c*3+1]), cells[c*3+2]);
            mid_next[c] = med3(cells[c*3], cells[c*3+1], cells[c*3+2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        mid_reg     <= mid_next;
        hi_reg      <= hi_next;
        max_lo_reg  <= max2(max2(lo_reg[0], lo_reg[1]), lo_reg[2]);
        med_mid_reg <= med3(mid_reg[0], mid_reg[1], mid_reg[2]);
        min_hi_reg  <= min2(min2(hi_reg[0], hi_reg[1]), hi_reg[2]);
        median_reg  <= med3(max_lo_reg, med_mid_reg, min_hi_reg);
    end

    assign tag_out = tag_c_reg;
    assign median  = median_reg;

endmodule

FILE: rtl/median_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// 3x3 median filter over a raster-order pixel stream with zero padding.
// ----------------------------------------------------------------------------
// The unit takes one item per clock. The two previous image rows live in one
// line RAM (upper and middle pixel side by side) that every item reads at its
// column and writes back in the next cycle; a back-to-back access to the
// same column is forwarded around the RAM. The result of the item completing
// its neighborhood leaves the median tree and waits in an eight-entry output
// queue; the input stalls only when eight results are in flight or queued,
// so with the output taking one result per cycle the rate stays one item per
// cycle. The line RAM needs no clearing after reset: border masking hides
// every entry not yet written. One image takes width*height+width+1 items
// (the trailing ones flush items) and yields width*height results. A write
// to either configuration register restarts the image.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit #(
    parameter int MAX_WIDTH = mf3_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    mf3_pixel_if.sink                          pixels,
    mf3_result_if.source                       results,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mf3_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [mf3_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [mf3_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int EW_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS  = mf3_pkg::ROW_BITS;
    localparam int PB        = mf3_pkg::PIXEL_BITS;
    localparam int PTR_BITS  = $clog2(mf3_pkg::FIFO_DEPTH);
    localparam int PEND_BITS = $clog2(mf3_pkg::FIFO_DEPTH + 1);

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } edge_mask_t;

    typedef struct packed {
        logic       valid;
        logic       emit;
        logic       last;
        edge_mask_t mask;
    } s1_ctrl_t;

    typedef struct packed {
        mf3_pkg::pixel_t median;
        logic            last;
    } result_t;

    // ---------------- configuration ----------------
    logic [mf3_pkg::WIDTH_REG_BITS-1:0]  image_width_reg;
    logic [mf3_pkg::HEIGHT_REG_BITS-1:0] image_height_reg;
    cfg_index_t                          cfg_idx;
    logic                                cfg_we;
    logic [EW_BITS-1:0]                  eff_w;
    logic [ROW_BITS-1:0]                 eff_h;
    logic [ROW_BITS-1:0]                 h_plus1;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_index_t'(paddr[2]);
    assign cfg_we  = psel & penable & pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = mf3_pkg::CFG_DATA_BITS'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = mf3_pkg::CFG_DATA_BITS'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= mf3_pkg::WIDTH_REG_BITS'(mf3_pkg::WIDTH_RESET);
            image_height_reg <= mf3_pkg::HEIGHT_REG_BITS'(mf3_pkg::HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[mf3_pkg::WIDTH_REG_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[mf3_pkg::HEIGHT_REG_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // saturate the registers into the usable range
    always_comb
    begin
        if (image_width_reg == '0)
            eff_w = EW_BITS'(1);
        else if (32'(image_width_reg) > MAX_WIDTH)
            eff_w = EW_BITS'(MAX_WIDTH);
        else
            eff_w = EW_BITS'(image_width_reg);

        if (image_height_reg == '0)
            eff_h = ROW_BITS'(1);
        else if (image_height_reg > ROW_BITS'(mf3_pkg::MAX_HEIGHT))
            eff_h = ROW_BITS'(mf3_pkg::MAX_HEIGHT);
        else
            eff_h = image_height_reg;
    end

    assign h_plus1 = eff_h + ROW_BITS'(1);

    // ---------------- position and item decode ----------------
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [EW_BITS-1:0]  col_inc;
    logic [PEND_BITS-1:0] pending_reg, pending_next;
    logic                accept;
    logic                col_zero;
    s1_ctrl_t            s0_ctrl;
    mf3_pkg::pixel_t     s0_pix;

    assign pixels.ready = (pending_reg < PEND_BITS'(mf3_pkg::FIFO_DEPTH));
    assign accept       = pixels.valid & pixels.ready;
    assign col_zero     = (col_reg == '0);
    assign col_inc      = EW_BITS'(col_reg) + EW_BITS'(1);

    always_comb
    begin
        s0_ctrl.valid = accept;
        s0_ctrl.emit  = (row_reg >= ROW_BITS'(2)) ||
                        ((row_reg == ROW_BITS'(1)) && !col_zero);
        s0_ctrl.last  = s0_ctrl.emit && (row_reg == h_plus1) && col_zero;
        // borders of the pixel whose neighborhood completes with this item
        s0_ctrl.mask.left   = (col_reg == COL_BITS'(1)) ||
                              (col_zero && (eff_w == EW_BITS'(1)));
        s0_ctrl.mask.right  = col_zero;
        s0_ctrl.mask.top    = col_zero ? (row_reg == ROW_BITS'(2)) :
                                         (row_reg == ROW_BITS'(1));
        s0_ctrl.mask.bottom = col_zero ? (row_reg == h_plus1) : (row_reg == eff_h);

        s0_pix = (!pixels.cmd && (row_reg < eff_h)) ? pixels.pixel : '0;

        if (row_reg >= h_plus1)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= eff_w)
        begin
            col_next = '0;
            row_next = row_reg + ROW_BITS'(1);
        end
        else
        begin
            col_next = col_inc[COL_BITS-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1: line RAM read-modify-write ----------------
    s1_ctrl_t            s1_ctrl_reg;
    logic [COL_BITS-1:0] s1_addr_reg;
    mf3_pkg::pixel_t     s1_pix_reg;
    logic                fwd_hit_reg;
    mf3_pkg::pixel_t     fwd_upper_reg, fwd_middle_reg;
    logic [2*PB-1:0]     line_rd;
    mf3_pkg::pixel_t     above2, above1;

    mf3_ram #(
        .WIDTH (2 * PB),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_ctrl_reg.valid),
        .waddr (s1_addr_reg),
        .wdata ({above1, s1_pix_reg}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (line_rd)
    );

    // take the write of the previous item when it hit the same column
    assign above2 = fwd_hit_reg ? fwd_upper_reg  : line_rd[2*PB-1:PB];
    assign above1 = fwd_hit_reg ? fwd_middle_reg : line_rd[PB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            s1_ctrl_reg <= s0_ctrl;
            fwd_hit_reg <= accept && s1_ctrl_reg.valid && (s1_addr_reg == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg    <= col_reg;
            s1_pix_reg     <= s0_pix;
            fwd_upper_reg  <= above1;
            fwd_middle_reg <= s1_pix_reg;
        end
    end

    // ---------------- window and stage 2: border masking ----------------
    mf3_pkg::pixel_t   window_reg [mf3_pkg::WIN_CELLS];
    mf3_pkg::pixel_t   masked     [mf3_pkg::WIN_CELLS];
    mf3_pkg::med_tag_t s2_tag_reg;
    edge_mask_t        s2_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mf3_pkg::WIN_CELLS; i++)
                window_reg[i] <= '0;
            s2_tag_reg  <= '0;
            s2_mask_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                for (int i = 0; i < mf3_pkg::WIN_CELLS; i++)
                    window_reg[i] <= '0;
            end
            else if (s1_ctrl_reg.valid)
            begin
                // advance one column: oldest column drops, new column enters right
                for (int i = 0; i < 6; i++)
                    window_reg[i] <= window_reg[i+3];
                window_reg[6] <= above2;
                window_reg[7] <= above1;
                window_reg[8] <= s1_pix_reg;
            end
            s2_tag_reg.valid <= s1_ctrl_reg.valid & s1_ctrl_reg.emit;
            s2_tag_reg.last  <= s1_ctrl_reg.last;
            s2_mask_reg      <= s1_ctrl_reg.mask;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if ((c == 0 && s2_mask_reg.left)  || (c == 2 && s2_mask_reg.right) ||
                    (r == 0 && s2_mask_reg.top)   || (r == 2 && s2_mask_reg.bottom))
                    masked[c*3+r] = '0;
                else
                    masked[c*3+r] = window_reg[c*3+r];
            end
        end
    end

    // ---------------- median network ----------------
    mf3_pkg::med_tag_t med_tag;
    mf3_pkg::pixel_t   med_value;

    mf3_median u_median (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (s2_tag_reg),
        .cells   (masked),
        .tag_out (med_tag),
        .median  (med_value)
    );

    // ---------------- output queue ----------------
    result_t           fifo_mem [mf3_pkg::FIFO_DEPTH];
    logic [PTR_BITS:0] wr_ptr_reg, rd_ptr_reg;
    logic              pop;
    result_t           head;

    assign head           = fifo_mem[rd_ptr_reg[PTR_BITS-1:0]];
    assign results.valid  = (wr_ptr_reg != rd_ptr_reg);
    assign results.median = head.median;
    assign results.last   = head.last;
    assign pop            = results.valid & results.ready;

    always_ff @(posedge clk)
    begin
        if (med_tag.valid)
        begin
            fifo_mem[wr_ptr_reg[PTR_BITS-1:0]] <= '{median: med_value, last: med_tag.last};
        end
    end

    // count results owed: in the pipeline or waiting in the queue
    always_comb
    begin
        pending_next = pending_reg;
        if (accept && s0_ctrl.emit && !pop)
            pending_next = pending_reg + PEND_BITS'(1);
        else if (!(accept && s0_ctrl.emit) && pop)
            pending_next = pending_reg - PEND_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (med_tag.valid)
                wr_ptr_reg <= wr_ptr_reg + (PTR_BITS+1)'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + (PTR_BITS+1)'(1);
            pending_reg <= pending_next;
        end
    end

endmodule
